// ===== rtl/fste_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and reciprocal tables for the Fourier-series thrust evaluator.
package fste_pkg;

	// configuration register indexes
	localparam logic [2:0] CFG_TIME_FINAL  = 3'd0;
	localparam logic [2:0] CFG_THRUST_EN   = 3'd1;
	localparam logic [2:0] CFG_COAST_THR   = 3'd2;
	localparam logic [2:0] CFG_GAMMA_COUNT = 3'd3;
	localparam logic [2:0] CFG_TAU_COUNT   = 3'd4;
	localparam logic [2:0] CFG_COAST_COUNT = 3'd5;

	// item kinds
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_EVAL = 1'b1;

	// tables
	localparam logic [1:0] TBL_GAMMA = 2'd0;
	localparam logic [1:0] TBL_TAU   = 2'd1;
	localparam logic [1:0] TBL_COAST = 2'd2;
	localparam logic [1:0] TBL_NONE  = 2'd3;

	// fixed-point constants
	localparam logic [30:0] ONE_Q30     = 31'd1073741824;
	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
	localparam logic [25:0] PI_Q24      = 26'd52707179;
	// 41 * pi, lifts any 32-bit signed value to a nonnegative one
	localparam logic signed [33:0] PI_BIAS = 34'sd2160994339;

	localparam logic [2:0] SIN_LAST = 3'd5;
	localparam logic [2:0] COS_LAST = 3'd6;

	typedef enum logic [4:0] {
		ST_IDLE, ST_DIV, ST_SINIT, ST_C0, ST_NEXT, ST_TX, ST_TX2, ST_TSQ,
		ST_TH1, ST_TH2, ST_TH3, ST_TH4, ST_TEND, ST_TSF, ST_TQUAD,
		ST_RD1, ST_RD2, ST_RD3, ST_RD4, ST_SDONE, ST_MINIT, ST_MOD,
		ST_FOLD, ST_CX, ST_CSQ, ST_OUT
	} fste_state_t;

	// Taylor denominators of the Horner steps
	function automatic logic [7:0] horner_den(input logic cosm, input logic [2:0] k);
		logic [7:0] d;
		case ({cosm, k})
			4'b0000: d = 8'd156;
			4'b0001: d = 8'd110;
			4'b0010: d = 8'd72;
			4'b0011: d = 8'd42;
			4'b0100: d = 8'd20;
			4'b0101: d = 8'd6;
			4'b1000: d = 8'd182;
			4'b1001: d = 8'd132;
			4'b1010: d = 8'd90;
			4'b1011: d = 8'd56;
			4'b1100: d = 8'd30;
			4'b1101: d = 8'd12;
			4'b1110: d = 8'd2;
			default: d = 8'd1;
		endcase
		return d;
	endfunction

	// floor(2^32 / den), estimate is exact or one low
	function automatic logic [31:0] horner_rcp(input logic cosm, input logic [2:0] k);
		logic [31:0] r;
		case ({cosm, k})
			4'b0000: r = 32'd27531841;
			4'b0001: r = 32'd39045157;
			4'b0010: r = 32'd59652323;
			4'b0011: r = 32'd102261126;
			4'b0100: r = 32'd214748364;
			4'b0101: r = 32'd715827882;
			4'b1000: r = 32'd23598721;
			4'b1001: r = 32'd32537631;
			4'b1010: r = 32'd47721858;
			4'b1011: r = 32'd76695844;
			4'b1100: r = 32'd143165576;
			4'b1101: r = 32'd357913941;
			4'b1110: r = 32'd2147483648;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/fourier_series_thrust_eval.sv =====
`timescale 1ns / 1ps
// Top level: coefficient memory, shared multiplier and the evaluation sequencer.
//
// Load items (kind 0) write one coefficient in the cycle they are accepted and
// leave busy low. An evaluate item (kind 1) raises busy and, when done, puts
// gamma_value, tau_value and thrust_on out for one cycle with done high; the
// receiver cannot stall, so it must take the item in that cycle. With thrust
// disabled the item returns zeros. Otherwise it runs the restoring ratio
// division (skipped when cur_time is not below the final time), then the
// sin/cos Horner recurrences for each harmonic of the three tables (at most
// 21 in all), then the coast sine squared. All products go through one
// shared 33x33 multiplier, and each Horner term steps through product,
// reciprocal multiply, correct and subtract.
// Coefficients live in a one-port-read synchronous memory; entries read before
// written hold whatever the memory powered up with. Config writes are taken
// only while busy is low.
module fourier_series_thrust_eval #(
	parameter int COEFF_SLOTS = 16,
	parameter int COEFF_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	// item command
	input  logic               start,
	output logic               busy,
	input  logic               kind,
	input  logic [1:0]         series_select,
	input  logic [3:0]         coeff_index,
	input  logic signed [31:0] coeff_value,
	input  logic [31:0]        cur_time,
	// result
	output logic               done,
	output logic signed [31:0] gamma_value,
	output logic signed [31:0] tau_value,
	output logic               thrust_on,
	// configuration write
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	// store keeps at most 32 bits of each value
	localparam int SW    = (COEFF_WIDTH < 32) ? COEFF_WIDTH : 32;
	localparam int DEPTH = 3 * COEFF_SLOTS;
	localparam int AW    = $clog2(DEPTH);
	// last harmonic whose sine slot lies in the table
	localparam int HLIM  = (COEFF_SLOTS - 1) / 2;

	fste_pkg::fste_state_t state_q, state_d;

	// configuration
	logic [31:0] tf_q;
	logic        en_q;
	logic [24:0] thr_q;
	logic [3:0]  gcnt_q, tcnt_q, ccnt_q;

	// coefficient memory
	logic [SW-1:0]      mem [DEPTH];
	logic [AW-1:0]      rd_addr;
	logic [SW-1:0]      rd_q;
	logic               we;
	logic [AW-1:0]      wa;
	logic signed [32:0] rd_ext;

	// shared multiplier
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod_q;

	// sequencer datapath
	logic [32:0]        rem_q;
	logic [23:0]        quo_q;       // ratio, Q0.24 low bits
	logic [4:0]         dcnt_q;
	logic [1:0]         table_q;
	logic [2:0]         n_q, nmax_q;
	logic [23:0]        phase_q;
	logic signed [63:0] acc_q;
	logic [30:0]        x_q;
	logic [31:0]        x2_q;
	logic [30:0]        u_q;
	logic [30:0]        s_q;
	logic [2:0]         k_q;
	logic               cosm_q;      // cosine recurrence running
	logic               cm_q;        // coast post-processing
	logic [31:0]        m_q;
	logic [31:0]        q0_q;
	logic [8:0]         rm_q;
	logic signed [25:0] cv_q, sv_q;
	logic signed [31:0] g_q, t_q, cs_q;
	logic               thr_on_q;
	logic [32:0]        v_q;
	logic [2:0]         mk_q;

	// combinational helpers
	logic               accept;
	logic [AW-1:0]      tbase;
	logic [AW-1:0]      slot2n;
	logic [3:0]         cnt_sel;
	logic [2:0]         harm;
	logic [2:0]         nmax_d;
	logic [32:0]        div_r2;
	logic               div_bit;
	logic [7:0]         den;
	logic [32:0]        q_corr;
	logic [30:0]        u_new;
	logic signed [63:0] acc_fl;
	logic signed [31:0] acc_sat;
	logic signed [33:0] v_sum;
	logic [32:0]        pi_sh;
	logic [25:0]        fold_d;
	logic [25:0]        fold_r;
	logic signed [25:0] s24, k24;
	logic [39:0]        rem_full;

	assign accept    = start && !busy;
	assign busy      = (state_q != fste_pkg::ST_IDLE);
	assign cfg_ready = !busy;

	assign done        = (state_q == fste_pkg::ST_OUT);
	assign gamma_value = g_q;
	assign tau_value   = t_q;
	assign thrust_on   = thr_on_q;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tf_q   <= 32'd1;
			en_q   <= 1'b0;
			thr_q  <= '0;
			gcnt_q <= 4'd1;
			tcnt_q <= 4'd1;
			ccnt_q <= 4'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				fste_pkg::CFG_TIME_FINAL:  tf_q   <= cfg_data;
				fste_pkg::CFG_THRUST_EN:   en_q   <= cfg_data[0];
				fste_pkg::CFG_COAST_THR:   thr_q  <= cfg_data[24:0];
				fste_pkg::CFG_GAMMA_COUNT: gcnt_q <= cfg_data[3:0];
				fste_pkg::CFG_TAU_COUNT:   tcnt_q <= cfg_data[3:0];
				fste_pkg::CFG_COAST_COUNT: ccnt_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- memory
	// loads to the unused selector or past the table are dropped
	assign we = accept && (kind == fste_pkg::KIND_LOAD) &&
		(series_select != fste_pkg::TBL_NONE) && (32'(coeff_index) < COEFF_SLOTS);
	assign wa = AW'(AW'(series_select) * AW'(COEFF_SLOTS) + AW'(coeff_index));

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= coeff_value[SW-1:0];
		end
		rd_q <= mem[rd_addr];
	end

	assign rd_ext = {{(33 - SW){rd_q[SW-1]}}, rd_q};

	// ---------------------------------------------------------------- multiplier
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// ---------------------------------------------------------------- helpers
	assign tbase  = AW'(AW'(table_q) * AW'(COEFF_SLOTS));
	assign slot2n = AW'({n_q, 1'b0});

	always_comb begin
		case (table_q)
			fste_pkg::TBL_GAMMA: cnt_sel = gcnt_q;
			fste_pkg::TBL_TAU:   cnt_sel = tcnt_q;
			default:             cnt_sel = ccnt_q;
		endcase
	end
	// harmonic count (count-1)/2, capped so both slots stay in the table
	assign harm   = (cnt_sel == 4'd0) ? 3'd0 : 3'((cnt_sel - 4'd1) >> 1);
	assign nmax_d = (int'(harm) < HLIM) ? harm : 3'(HLIM);

	// restoring division, dividend low bits are all zero
	assign div_r2  = {rem_q[31:0], 1'b0};
	assign div_bit = (div_r2 >= {1'b0, tf_q});

	// reciprocal estimate correction and floored subtract from one
	assign den      = fste_pkg::horner_den(cosm_q, k_q);
	assign rem_full = 40'(m_q) - 40'(prod_q[63:32]) * 40'(den);
	assign q_corr   = 33'(q0_q) + 33'(rm_q >= 9'(den));
	assign u_new    = (q_corr < 33'(fste_pkg::ONE_Q30)) ?
		31'(33'(fste_pkg::ONE_Q30) - q_corr) : '0;

	// floor to Q24 and saturate to 32 bits
	assign acc_fl  = acc_q >>> 24;
	assign acc_sat = (acc_fl > 64'sd2147483647)  ? 32'sh7fffffff :
		(acc_fl < -64'sd2147483648) ? 32'sh80000000 : acc_fl[31:0];

	// coast sum modulo pi, then folded into [0, pi/2]
	assign v_sum  = 34'(cs_q) + fste_pkg::PI_BIAS;
	assign pi_sh  = 33'(fste_pkg::PI_Q24) << mk_q;
	assign fold_d = fste_pkg::PI_Q24 - v_q[25:0];
	assign fold_r = (fold_d < v_q[25:0]) ? fold_d : v_q[25:0];

	assign s24 = {1'b0, s_q[30:6]};
	assign k24 = {1'b0, u_q[30:6]};

	// ---------------------------------------------------------------- FSM
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fste_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		mul_a   = '0;
		mul_b   = '0;
		rd_addr = tbase;
		case (state_q)
			fste_pkg::ST_IDLE: begin
				if (start && kind == fste_pkg::KIND_EVAL) begin
					if (!en_q) begin
						state_d = fste_pkg::ST_OUT;
					end else if (tf_q == 32'd0 || cur_time >= tf_q) begin
						state_d = fste_pkg::ST_SINIT;
					end else begin
						state_d = fste_pkg::ST_DIV;
					end
				end
			end
			fste_pkg::ST_DIV: begin
				if (dcnt_q == 5'd0) begin
					state_d = fste_pkg::ST_SINIT;
				end
			end
			fste_pkg::ST_SINIT: state_d = fste_pkg::ST_C0;
			fste_pkg::ST_C0:    state_d = fste_pkg::ST_NEXT;
			fste_pkg::ST_NEXT: begin
				state_d = (n_q < nmax_q) ? fste_pkg::ST_TX : fste_pkg::ST_SDONE;
			end
			fste_pkg::ST_TX: begin
				mul_a   = 33'(phase_q[21:0]);
				mul_b   = 33'(fste_pkg::HALF_PI_Q30);
				state_d = fste_pkg::ST_TX2;
			end
			fste_pkg::ST_TX2: begin
				mul_a   = 33'(prod_q[52:22]);
				mul_b   = 33'(prod_q[52:22]);
				state_d = fste_pkg::ST_TSQ;
			end
			fste_pkg::ST_TSQ: state_d = fste_pkg::ST_TH1;
			fste_pkg::ST_TH1: begin
				mul_a   = 33'(x2_q);
				mul_b   = 33'(u_q);
				state_d = fste_pkg::ST_TH2;
			end
			fste_pkg::ST_TH2: begin
				mul_a   = 33'(prod_q[61:30]);
				mul_b   = 33'(fste_pkg::horner_rcp(cosm_q, k_q));
				state_d = fste_pkg::ST_TH3;
			end
			fste_pkg::ST_TH3: state_d = fste_pkg::ST_TH4;
			fste_pkg::ST_TH4: begin
				if (k_q == (cosm_q ? fste_pkg::COS_LAST : fste_pkg::SIN_LAST)) begin
					state_d = fste_pkg::ST_TEND;
				end else begin
					state_d = fste_pkg::ST_TH1;
				end
			end
			fste_pkg::ST_TEND: begin
				if (!cosm_q) begin
					mul_a   = 33'(x_q);
					mul_b   = 33'(u_q);
					state_d = fste_pkg::ST_TSF;
				end else begin
					state_d = fste_pkg::ST_TQUAD;
				end
			end
			fste_pkg::ST_TSF: begin
				if (cm_q) begin
					mul_a   = 33'(prod_q[60:30]);
					mul_b   = 33'(prod_q[60:30]);
					state_d = fste_pkg::ST_CSQ;
				end else begin
					state_d = fste_pkg::ST_TH1;
				end
			end
			fste_pkg::ST_TQUAD: state_d = fste_pkg::ST_RD1;
			fste_pkg::ST_RD1: begin
				rd_addr = AW'(tbase + slot2n - AW'(1));
				state_d = fste_pkg::ST_RD2;
			end
			fste_pkg::ST_RD2: begin
				mul_a   = rd_ext;
				mul_b   = 33'(cv_q);
				rd_addr = AW'(tbase + slot2n);
				state_d = fste_pkg::ST_RD3;
			end
			fste_pkg::ST_RD3: begin
				mul_a   = rd_ext;
				mul_b   = 33'(sv_q);
				state_d = fste_pkg::ST_RD4;
			end
			fste_pkg::ST_RD4: state_d = fste_pkg::ST_NEXT;
			fste_pkg::ST_SDONE: begin
				state_d = (table_q == fste_pkg::TBL_COAST) ?
					fste_pkg::ST_MINIT : fste_pkg::ST_SINIT;
			end
			fste_pkg::ST_MINIT: state_d = fste_pkg::ST_MOD;
			fste_pkg::ST_MOD: begin
				if (mk_q == 3'd0) begin
					state_d = fste_pkg::ST_FOLD;
				end
			end
			fste_pkg::ST_FOLD: state_d = fste_pkg::ST_CX;
			fste_pkg::ST_CX: begin
				mul_a   = 33'(x_q);
				mul_b   = 33'(x_q);
				state_d = fste_pkg::ST_TSQ;
			end
			fste_pkg::ST_CSQ: state_d = fste_pkg::ST_OUT;
			fste_pkg::ST_OUT: state_d = fste_pkg::ST_IDLE;
			default:          state_d = fste_pkg::ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------- datapath
	always_ff @(posedge clk) begin
		case (state_q)
			fste_pkg::ST_IDLE: begin
				if (start && kind == fste_pkg::KIND_EVAL) begin
					rem_q    <= {1'b0, cur_time};
					quo_q    <= '0;      // ratio of one has zero low bits
					dcnt_q   <= 5'd23;
					table_q  <= fste_pkg::TBL_GAMMA;
					cm_q     <= 1'b0;
					g_q      <= '0;
					t_q      <= '0;
					thr_on_q <= 1'b0;
				end
			end
			fste_pkg::ST_DIV: begin
				rem_q  <= div_bit ? (div_r2 - {1'b0, tf_q}) : div_r2;
				quo_q  <= {quo_q[22:0], div_bit};
				dcnt_q <= dcnt_q - 5'd1;
			end
			fste_pkg::ST_SINIT: begin
				nmax_q  <= nmax_d;
				n_q     <= '0;
				phase_q <= '0;
			end
			fste_pkg::ST_C0: begin
				acc_q <= 64'(rd_ext) <<< 24;
			end
			fste_pkg::ST_NEXT: begin
				if (n_q < nmax_q) begin
					n_q     <= n_q + 3'd1;
					phase_q <= phase_q + quo_q;
				end
			end
			fste_pkg::ST_TX2: begin
				x_q <= prod_q[52:22];
			end
			fste_pkg::ST_TSQ: begin
				x2_q   <= prod_q[61:30];
				u_q    <= fste_pkg::ONE_Q30;
				k_q    <= '0;
				cosm_q <= 1'b0;
			end
			fste_pkg::ST_TH2: begin
				m_q <= prod_q[61:30];
			end
			fste_pkg::ST_TH3: begin
				q0_q <= prod_q[63:32];
				rm_q <= rem_full[8:0];
			end
			fste_pkg::ST_TH4: begin
				u_q <= u_new;
				k_q <= k_q + 3'd1;
			end
			fste_pkg::ST_TSF: begin
				if (!cm_q) begin
					s_q    <= prod_q[60:30];
					u_q    <= fste_pkg::ONE_Q30;
					k_q    <= '0;
					cosm_q <= 1'b1;
				end
			end
			fste_pkg::ST_TQUAD: begin
				case (phase_q[23:22])
					2'd0: begin cv_q <= k24;  sv_q <= s24;  end
					2'd1: begin cv_q <= -s24; sv_q <= k24;  end
					2'd2: begin cv_q <= -k24; sv_q <= -s24; end
					default: begin cv_q <= s24; sv_q <= -k24; end
				endcase
			end
			fste_pkg::ST_RD3, fste_pkg::ST_RD4: begin
				acc_q <= acc_q + signed'(prod_q[63:0]);
			end
			fste_pkg::ST_SDONE: begin
				case (table_q)
					fste_pkg::TBL_GAMMA: g_q  <= acc_sat;
					fste_pkg::TBL_TAU:   t_q  <= acc_sat;
					default:             cs_q <= acc_sat;
				endcase
				table_q <= table_q + 2'd1;
			end
			fste_pkg::ST_MINIT: begin
				v_q  <= 33'(v_sum);
				mk_q <= 3'd6;
				cm_q <= 1'b1;
			end
			fste_pkg::ST_MOD: begin
				if (v_q >= pi_sh) begin
					v_q <= v_q - pi_sh;
				end
				mk_q <= mk_q - 3'd1;
			end
			fste_pkg::ST_FOLD: begin
				x_q <= 31'({fold_r, 6'd0});
			end
			fste_pkg::ST_CSQ: begin
				thr_on_q <= (prod_q[60:36] >= thr_q);
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/fste_chk.sv =====
`timescale 1ns / 1ps
// Port-level checker for the evaluator, bound to the top level.
module fste_chk (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic kind,
	input logic done
);

	// a result only comes out while an evaluate item is in flight
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe without busy");

	// a load item never produces a result
	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind == fste_pkg::KIND_LOAD) |=> !done)
		else $error("result after a load item");

	// an evaluate item always occupies the block
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind == fste_pkg::KIND_EVAL) |=> busy)
		else $error("evaluate item did not raise busy");

	// after its result the block is free again
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy && !done)
		else $error("busy held after result");

endmodule

bind fourier_series_thrust_eval fste_chk u_fste_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.kind   (kind),
	.done   (done)
);
